// ===== rtl/gfc_pkg.sv =====
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and constants of the frame compositor: item layouts,
// configuration record, register indexes and interlace pass tables.
// ----------------------------------------------------------------------------
package gfc_pkg;

    // palette depth and counter width
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COORD_BITS      = 16;

    // colour word constants
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // input item: palette write or pixel index
    typedef struct packed {
        logic       mode;
        logic [7:0] palette_slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] color_index;
    } t_in_item;

    // result item: one canvas pixel write
    typedef struct packed {
        logic [31:0] pixel_address;
        logic [31:0] pixel_word;
        logic        write_enable;
        logic        frame_last;
    } t_out_item;

    // item modes
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FRAME_LEFT   = 3'd0,
        REG_FRAME_TOP    = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_CANVAS_WIDTH = 3'd4,
        REG_TRANSP_INDEX = 3'd5,
        REG_BG_INDEX     = 3'd6,
        REG_FRAME_FLAGS  = 3'd7
    } t_reg_idx;

    // frame flag bits
    localparam int FLAG_TRANSP    = 0;
    localparam int FLAG_CONTROL   = 1;
    localparam int FLAG_INTERLACE = 2;

    // configuration record
    typedef struct packed {
        logic [15:0] frame_left;
        logic [15:0] frame_top;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] canvas_width;
        logic [7:0]  transparent_index;
        logic [7:0]  background_index;
        logic [2:0]  frame_flags;
    } t_cfg;

    // address part computed at the raster stage
    typedef struct packed {
        logic [31:0] row_base;
        logic [16:0] col_sum;
        logic        last;
    } t_addr_part;

    // interlace passes: first row and row step
    localparam logic [3:0] PASS_FIRST [4] = '{4'd0, 4'd4, 4'd2, 4'd1};
    localparam logic [3:0] PASS_STEP  [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

endpackage

// ===== rtl/gfc_palette.sv =====
// ----------------------------------------------------------------------------
// gfc_palette
// Palette memory: one write port and one registered read port, 24-bit
// blue/green/red entries.
// ----------------------------------------------------------------------------
module gfc_palette
    import gfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [PAL_AW-1:0] i_wr_slot,
    input  logic [23:0]       i_wr_bgr,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_slot,
    output logic [23:0]       o_rd_bgr
);

    logic [23:0] r_mem [PALETTE_ENTRIES];
    logic [23:0] r_rd_bgr;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_bgr;
        end
    end

    // registered read, held while no new lookup is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bgr <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_bgr = r_rd_bgr;

endmodule

// ===== rtl/gfc_raster.sv =====
// ----------------------------------------------------------------------------
// gfc_raster
// Frame position counters with interlaced row order, and the registered
// row base and column sum of the canvas address.
// ----------------------------------------------------------------------------
module gfc_raster
    import gfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    output t_addr_part o_part
);

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_rows;
    logic [COORD_BITS-1:0] r_target;
    logic [1:0]            r_pass;
    t_addr_part            r_part;

    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_rows;
    logic [COORD_BITS-1:0] n_target;
    logic [1:0]            n_pass;

    logic [15:0] width;
    logic [15:0] height;
    logic        row_end;
    logic        last;
    logic [16:0] row_sum;
    logic [32:0] row_prod;
    logic [16:0] il_row;
    logic [1:0]  il_pass;

    // zero sizes act as one
    assign width  = (i_cfg.frame_width == '0) ? 16'd1 : i_cfg.frame_width;
    assign height = (i_cfg.frame_height == '0) ? 16'd1 : i_cfg.frame_height;

    // row and frame end
    assign row_end = (17'(r_col) + 17'd1) >= 17'(width);
    assign last    = row_end && ((17'(r_rows) + 17'd1) >= 17'(height));

    // address pieces of the current pixel
    assign row_sum  = 17'(i_cfg.frame_top) + 17'(r_target);
    assign row_prod = 33'(row_sum) * 33'(i_cfg.canvas_width);

    // next interlaced row, skipping passes that start past the frame
    always_comb begin
        il_pass = r_pass;
        il_row  = 17'(r_target) + 17'(PASS_STEP[r_pass]);
        for (int k = 0; k < 3; k++) begin
            if (il_row >= 17'(height) && il_pass != 2'd3) begin
                il_pass = il_pass + 2'd1;
                il_row  = 17'(PASS_FIRST[il_pass]);
            end
        end
    end

    // counter update
    always_comb begin
        n_col    = r_col;
        n_rows   = r_rows;
        n_target = r_target;
        n_pass   = r_pass;
        if (last) begin
            n_col    = '0;
            n_rows   = '0;
            n_target = '0;
            n_pass   = '0;
        end else if (row_end) begin
            n_col  = '0;
            n_rows = r_rows + COORD_BITS'(1);
            if (i_cfg.frame_flags[FLAG_INTERLACE]) begin
                n_target = il_row[COORD_BITS-1:0];
                n_pass   = il_pass;
            end else begin
                n_target = r_target + COORD_BITS'(1);
            end
        end else begin
            n_col = r_col + COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_rows   <= '0;
            r_target <= '0;
            r_pass   <= '0;
        end else if (i_step) begin
            r_col    <= n_col;
            r_rows   <= n_rows;
            r_target <= n_target;
            r_pass   <= n_pass;
        end
    end

    // address stage register
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_part.row_base <= row_prod[31:0];
            r_part.col_sum  <= 17'(i_cfg.frame_left) + 17'(r_col);
            r_part.last     <= last;
        end
    end

    assign o_part = r_part;

endmodule

// ===== rtl/gfc_top_unused_guard.sv =====
// ----------------------------------------------------------------------------
// gfc_colour
// Colour stage: forms the ABGR word, opaque unless the pixel is skipped, from
// the palette read and the transparency and range flags of the pixel.
// ----------------------------------------------------------------------------
module gfc_colour
    import gfc_pkg::*;
(
    input  logic [23:0] i_bgr,
    input  logic        i_skip,
    input  logic        i_black,
    output logic [31:0] o_word
);

    // skipped pixels carry a zero word, out-of-range entries read black
    always_comb begin
        if (i_skip) begin
            o_word = '0;
        end else if (i_black) begin
            o_word = {ALPHA_OPAQUE, 24'd0};
        end else begin
            o_word = {ALPHA_OPAQUE, i_bgr};
        end
    end

endmodule

// ===== rtl/gif_frame_compositor.sv =====
// ----------------------------------------------------------------------------
// gif_frame_compositor
// Maps palette writes and frame pixel indices to canvas pixel writes.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while the output side takes results. A
// pixel item's result passes through the first stage and then the output
// register. The accepting edge registers the palette read and the row base
// (row times canvas width). A later edge on which the pipe advances adds the
// column and fills the output register. Palette write items yield no result.
// The palette is not cleared at reset; a pixel must only use entries that were
// written before it.
// ----------------------------------------------------------------------------
module gif_frame_compositor
    import gfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_s1_valid;
    logic       r_s1_skip;
    logic       r_s1_black;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       advance;
    logic       accept;
    logic       pix_step;
    logic       pal_write;
    logic       is_transp;
    logic       skip;
    logic [7:0] lookup;
    logic [23:0] rd_bgr;
    logic [31:0] word;
    t_addr_part part;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_left        <= '0;
            r_cfg.frame_top         <= '0;
            r_cfg.frame_width       <= 16'd1;
            r_cfg.frame_height      <= 16'd1;
            r_cfg.canvas_width      <= 16'd1;
            r_cfg.transparent_index <= '0;
            r_cfg.background_index  <= '0;
            r_cfg.frame_flags       <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_LEFT:   r_cfg.frame_left        <= i_cfg_data;
                REG_FRAME_TOP:    r_cfg.frame_top         <= i_cfg_data;
                REG_FRAME_WIDTH:  r_cfg.frame_width       <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg.frame_height      <= i_cfg_data;
                REG_CANVAS_WIDTH: r_cfg.canvas_width      <= i_cfg_data;
                REG_TRANSP_INDEX: r_cfg.transparent_index <= i_cfg_data[7:0];
                REG_BG_INDEX:     r_cfg.background_index  <= i_cfg_data[7:0];
                REG_FRAME_FLAGS:  r_cfg.frame_flags       <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // pipeline flow: the whole pipe moves when the output register is free
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;
    assign pix_step   = accept && (i_in_item.mode == MODE_PIXEL);
    assign pal_write  = accept && (i_in_item.mode == MODE_PALETTE)
                        && ({1'b0, i_in_item.palette_slot} < 9'(PALETTE_ENTRIES));

    // transparency handling and palette lookup index
    assign is_transp = r_cfg.frame_flags[FLAG_CONTROL]
                       && (i_in_item.color_index == r_cfg.transparent_index);
    assign skip      = is_transp && r_cfg.frame_flags[FLAG_TRANSP];
    assign lookup    = is_transp ? r_cfg.background_index : i_in_item.color_index;

    gfc_palette u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_write),
        .i_wr_slot (i_in_item.palette_slot[PAL_AW-1:0]),
        .i_wr_bgr  ({i_in_item.blue, i_in_item.green, i_in_item.red}),
        .i_rd_en   (pix_step),
        .i_rd_slot (lookup[PAL_AW-1:0]),
        .o_rd_bgr  (rd_bgr)
    );

    gfc_raster u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (pix_step),
        .o_part  (part)
    );

    // first stage: valid and pixel flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_step) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_step) begin
            r_s1_skip  <= skip;
            r_s1_black <= ({1'b0, lookup} >= 9'(PALETTE_ENTRIES));
        end
    end

    gfc_colour u_colour (
        .i_bgr   (rd_bgr),
        .i_skip  (r_s1_skip),
        .i_black (r_s1_black),
        .o_word  (word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out.pixel_address <= part.row_base + 32'(part.col_sum);
            r_out.pixel_word    <= word;
            r_out.write_enable  <= !r_s1_skip;
            r_out.frame_last    <= part.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame compositor. A short directed list runs
// first: palette extremes, transparent skip, background substitution, zero
// sizes, an empty interlace pass, a width change inside a row and address
// wrap. Random phases follow, each with new register settings and a burst
// of palette writes and pixel indices. Every pixel write the block returns
// is compared field by field with a local model of the compositor.
// ----------------------------------------------------------------------------
module tb;
    import gfc_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES  = 10;
    localparam int          ITEM_TARGET  = 900;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int unsigned ROW_FIRST [4] = '{0, 4, 2, 1};
    localparam int unsigned ROW_STEP  [4] = '{8, 8, 4, 2};
    localparam t_cfg        RESET_CFG = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 8'd0, 8'd0, 3'd0};

    typedef struct {
        bit          is_reg;
        t_reg_idx    reg_idx;
        logic [15:0] reg_val;
        t_in_item    item;
        bit          fixed;
        t_out_item   res;
    } t_step;

    typedef struct {
        t_reg_idx    idx;
        logic [15:0] val;
    } t_reg_write;

    typedef struct {
        bit        fixed;
        t_out_item res;
    } t_fixed_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // model state: palette, registers, raster counters
    logic [23:0] palette_rgb [256];
    t_cfg        live_cfg;
    logic [15:0] col_pos = '0;
    logic [15:0] rows_seen = '0;
    logic [15:0] row_off = '0;
    logic [1:0]  pass_idx = '0;

    // stimulus side view of registers and palette
    t_cfg        plan_cfg;
    bit          loaded [256];
    t_reg_write  reg_writes [$];

    t_out_item   pixel_writes_due [$];
    t_fixed_res  fixed_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          idle_in_pct = 0;
    int          stall_pct = 0;

    gif_frame_compositor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // register update as the block sees it
    function automatic t_cfg with_reg(t_cfg c, t_reg_idx r, logic [15:0] v);
        case (r)
            REG_FRAME_LEFT:   c.frame_left = v;
            REG_FRAME_TOP:    c.frame_top = v;
            REG_FRAME_WIDTH:  c.frame_width = v;
            REG_FRAME_HEIGHT: c.frame_height = v;
            REG_CANVAS_WIDTH: c.canvas_width = v;
            REG_TRANSP_INDEX: c.transparent_index = v[7:0];
            REG_BG_INDEX:     c.background_index = v[7:0];
            REG_FRAME_FLAGS:  c.frame_flags = v[2:0];
            default: ;
        endcase
        return c;
    endfunction

    // expected canvas write for one item, advancing the raster counters
    task automatic compose_pixel(input t_in_item it, output bit made, output t_out_item px);
        int unsigned wid, hgt, nrow, pno;
        logic [23:0] rgb;
        logic [63:0] addr;
        bit          keep, row_end, last;
        made = 1'b0;
        px = '0;
        if (it.mode == MODE_PALETTE) begin
            palette_rgb[it.palette_slot] = {it.blue, it.green, it.red};
            return;
        end
        wid = (live_cfg.frame_width == 16'd0) ? 1 : live_cfg.frame_width;
        hgt = (live_cfg.frame_height == 16'd0) ? 1 : live_cfg.frame_height;
        keep = 1'b1;
        rgb = palette_rgb[it.color_index];
        if (live_cfg.frame_flags[FLAG_CONTROL] && it.color_index == live_cfg.transparent_index) begin
            if (live_cfg.frame_flags[FLAG_TRANSP]) begin
                keep = 1'b0;
                rgb = '0;
            end else begin
                rgb = palette_rgb[live_cfg.background_index];
            end
        end
        addr = (64'(live_cfg.frame_top) + 64'(row_off)) * 64'(live_cfg.canvas_width)
             + 64'(live_cfg.frame_left) + 64'(col_pos);
        row_end = (32'(col_pos) + 1) >= wid;
        last = row_end && ((32'(rows_seen) + 1) >= hgt);
        if (last) begin
            col_pos = '0;
            rows_seen = '0;
            row_off = '0;
            pass_idx = '0;
        end else if (row_end) begin
            col_pos = '0;
            rows_seen = rows_seen + 16'd1;
            if (!live_cfg.frame_flags[FLAG_INTERLACE]) begin
                row_off = row_off + 16'd1;
            end else begin
                // step within the pass, skipping passes that start past the frame
                pno = pass_idx;
                nrow = 32'(row_off) + ROW_STEP[pno];
                while (nrow >= hgt && pno < 3) begin
                    pno++;
                    nrow = ROW_FIRST[pno];
                end
                row_off = nrow[15:0];
                pass_idx = pno[1:0];
            end
        end else begin
            col_pos = col_pos + 16'd1;
        end
        made = 1'b1;
        px.pixel_address = addr[31:0];
        px.pixel_word = keep ? {ALPHA_OPAQUE, rgb} : 32'd0;
        px.write_enable = keep;
        px.frame_last = last;
    endtask

    // item builders, don't-care fields random
    function automatic t_in_item pal_item(logic [7:0] slot);
        t_in_item it;
        it.mode = MODE_PALETTE;
        it.palette_slot = slot;
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.color_index = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item pix_item(logic [7:0] cidx);
        t_in_item it;
        it = pal_item(8'($urandom));
        it.mode = MODE_PIXEL;
        it.color_index = cidx;
        return it;
    endfunction

    // directed list rows
    function automatic t_step pal_row(logic [7:0] slot, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
        t_step s;
        s = '{1'b0, REG_FRAME_LEFT, 16'd0, pal_item(slot), 1'b0, '0};
        s.item.red = r;
        s.item.green = g;
        s.item.blue = b;
        return s;
    endfunction

    function automatic t_step px_row(logic [7:0] cidx);
        return '{1'b0, REG_FRAME_LEFT, 16'd0, pix_item(cidx), 1'b0, '0};
    endfunction

    function automatic t_step px_fixed(logic [7:0] cidx, t_out_item res);
        return '{1'b0, REG_FRAME_LEFT, 16'd0, pix_item(cidx), 1'b1, res};
    endfunction

    function automatic t_step reg_row(t_reg_idx r, logic [15:0] v);
        return '{1'b1, r, v, '0, 1'b0, '0};
    endfunction

    function automatic void queue_reg(t_reg_idx r, logic [15:0] v);
        reg_writes.push_back('{r, v});
        plan_cfg = with_reg(plan_cfg, r, v);
    endfunction

    function automatic logic [15:0] pick_pos();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_size(int unsigned lim);
        case ($urandom_range(15))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom_range(1, lim));
        endcase
    endfunction

    // present one item and hold it until taken
    task automatic send(input t_in_item it);
        if (it.mode == MODE_PALETTE)
            loaded[it.palette_slot] = 1'b1;
        items_sent++;
        if (items_sent < 300) begin
            idle_in_pct = 29;
            stall_pct = 79;
        end else if (items_sent < 600) begin
            idle_in_pct = 79;
            stall_pct = 29;
        end else begin
            idle_in_pct = 0;
            stall_pct = 0;
        end
        while ($urandom_range(99) < idle_in_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // hold off until every expected pixel write has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_writes_due.size() != 0) @(posedge i_clk);
    endtask

    // register writes, only with the block idle
    task automatic apply_regs();
        t_reg_write w;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data <= w.val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // result side stalls
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // track accepted items and registers, check returned pixel writes
    always @(posedge i_clk) begin
        t_out_item  px;
        t_out_item  due;
        t_fixed_res fx;
        bit         made;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                live_cfg = with_reg(live_cfg, t_reg_idx'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                compose_pixel(i_in_item, made, px);
                fx = '{1'b0, '0};
                if (fixed_results.size() != 0)
                    fx = fixed_results.pop_front();
                if (made)
                    pixel_writes_due.push_back(fx.fixed ? fx.res : px);
            end
            if (o_out_valid && i_out_ready) begin
                if (pixel_writes_due.size() == 0) begin
                    $display("%0t: pixel write with none due: %h", $time, o_out_item);
                    mismatches++;
                end else begin
                    due = pixel_writes_due.pop_front();
                    if (o_out_item.pixel_address !== due.pixel_address) begin
                        $display("%0t: pixel_address expected %h got %h", $time,
                                 due.pixel_address, o_out_item.pixel_address);
                        mismatches++;
                    end
                    if (o_out_item.pixel_word !== due.pixel_word) begin
                        $display("%0t: pixel_word expected %h got %h", $time,
                                 due.pixel_word, o_out_item.pixel_word);
                        mismatches++;
                    end
                    if (o_out_item.write_enable !== due.write_enable) begin
                        $display("%0t: write_enable expected %b got %b", $time,
                                 due.write_enable, o_out_item.write_enable);
                        mismatches++;
                    end
                    if (o_out_item.frame_last !== due.frame_last) begin
                        $display("%0t: frame_last expected %b got %b", $time,
                                 due.frame_last, o_out_item.frame_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        t_step       steps [$];
        int          phase;
        int          burst;
        logic [7:0]  cidx;
        bit          ctl_hit;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        live_cfg = RESET_CFG;
        plan_cfg = RESET_CFG;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        steps = '{
            // palette extremes and one mid entry
            pal_row(8'h00, 8'h00, 8'h00, 8'h00),
            pal_row(8'hff, 8'hff, 8'hff, 8'hff),
            pal_row(8'h5a, 8'h12, 8'h34, 8'h56),
            // one-pixel frames after reset
            px_fixed(8'h00, '{32'd0, 32'hff00_0000, 1'b1, 1'b1}),
            px_fixed(8'hff, '{32'd0, 32'hffff_ffff, 1'b1, 1'b1}),
            px_fixed(8'h5a, '{32'd0, 32'hff56_3412, 1'b1, 1'b1}),
            // transparent index skipped
            reg_row(REG_TRANSP_INDEX, 16'h005a),
            reg_row(REG_FRAME_FLAGS, 16'h0003),
            px_fixed(8'h5a, '{32'd0, 32'd0, 1'b0, 1'b1}),
            // transparent index replaced by the background colour
            reg_row(REG_BG_INDEX, 16'h00ff),
            reg_row(REG_FRAME_FLAGS, 16'h0002),
            px_fixed(8'h5a, '{32'd0, 32'hffff_ffff, 1'b1, 1'b1}),
            // transparency bit without a control block
            reg_row(REG_FRAME_FLAGS, 16'h0001),
            px_fixed(8'h5a, '{32'd0, 32'hff56_3412, 1'b1, 1'b1}),
            // interlaced, three rows, second pass empty
            reg_row(REG_FRAME_FLAGS, 16'h0004),
            reg_row(REG_FRAME_HEIGHT, 16'd3),
            reg_row(REG_CANVAS_WIDTH, 16'd10),
            reg_row(REG_FRAME_LEFT, 16'd3),
            reg_row(REG_FRAME_TOP, 16'd1),
            px_row(8'h00),
            px_row(8'hff),
            px_row(8'h5a),
            // zero sizes act as one
            reg_row(REG_FRAME_WIDTH, 16'd0),
            reg_row(REG_FRAME_HEIGHT, 16'd0),
            reg_row(REG_FRAME_FLAGS, 16'h0000),
            px_fixed(8'h00, '{32'd13, 32'hff00_0000, 1'b1, 1'b1}),
            // width shrinks part way along a row
            reg_row(REG_FRAME_WIDTH, 16'd4),
            reg_row(REG_FRAME_HEIGHT, 16'd2),
            px_row(8'hff),
            px_row(8'h00),
            reg_row(REG_FRAME_WIDTH, 16'd1),
            px_row(8'h5a),
            px_row(8'hff),
            // address wraps past the far canvas corner
            reg_row(REG_FRAME_LEFT, 16'hffff),
            reg_row(REG_FRAME_TOP, 16'hffff),
            reg_row(REG_CANVAS_WIDTH, 16'hffff),
            reg_row(REG_FRAME_WIDTH, 16'd2),
            px_row(8'h00),
            px_row(8'hff),
            px_row(8'h5a),
            px_row(8'h00),
            // largest frame, first pixels only
            reg_row(REG_FRAME_WIDTH, 16'hffff),
            reg_row(REG_FRAME_HEIGHT, 16'hffff),
            reg_row(REG_TRANSP_INDEX, 16'h00ff),
            reg_row(REG_FRAME_FLAGS, 16'h0007),
            px_row(8'hff),
            px_row(8'h00)
        };

        // directed list
        foreach (steps[k]) begin
            if (steps[k].is_reg) begin
                queue_reg(steps[k].reg_idx, steps[k].reg_val);
            end else begin
                if (reg_writes.size() != 0)
                    apply_regs();
                fixed_results.push_back('{steps[k].fixed, steps[k].res});
                send(steps[k].item);
            end
        end

        // random phases: new settings, then a burst of items
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            if (phase == 1) begin
                queue_reg(REG_FRAME_LEFT, 16'hffff);
                queue_reg(REG_FRAME_TOP, 16'hffff);
                queue_reg(REG_CANVAS_WIDTH, 16'hffff);
                queue_reg(REG_FRAME_WIDTH, 16'd3);
                queue_reg(REG_FRAME_HEIGHT, 16'd5);
                queue_reg(REG_TRANSP_INDEX, 16'hffff);
                queue_reg(REG_BG_INDEX, 16'hffff);
                queue_reg(REG_FRAME_FLAGS, 16'hffff);
            end else if (phase == 2) begin
                queue_reg(REG_FRAME_LEFT, 16'd0);
                queue_reg(REG_FRAME_TOP, 16'd0);
                queue_reg(REG_CANVAS_WIDTH, 16'd0);
                queue_reg(REG_FRAME_WIDTH, 16'd0);
                queue_reg(REG_FRAME_HEIGHT, 16'd0);
                queue_reg(REG_TRANSP_INDEX, 16'd0);
                queue_reg(REG_BG_INDEX, 16'd0);
                queue_reg(REG_FRAME_FLAGS, 16'd0);
            end else begin
                if ($urandom_range(1)) queue_reg(REG_FRAME_LEFT, pick_pos());
                if ($urandom_range(1)) queue_reg(REG_FRAME_TOP, pick_pos());
                if ($urandom_range(1)) queue_reg(REG_CANVAS_WIDTH, pick_pos());
                if ($urandom_range(1)) queue_reg(REG_FRAME_WIDTH, pick_size(6));
                if ($urandom_range(1)) queue_reg(REG_FRAME_HEIGHT, pick_size(12));
                if ($urandom_range(1)) queue_reg(REG_TRANSP_INDEX, 16'($urandom));
                if ($urandom_range(1)) queue_reg(REG_BG_INDEX, 16'($urandom));
                if ($urandom_range(1)) queue_reg(REG_FRAME_FLAGS, 16'($urandom));
            end
            apply_regs();

            burst = $urandom_range(10, 50);
            repeat (burst) begin
                if ($urandom_range(39) == 0)
                    wait_drain();
                if ($urandom_range(99) < 12) begin
                    // stray palette write in the middle of a frame
                    send(pal_item(8'($urandom)));
                end else begin
                    cidx = ($urandom_range(3) == 0) ? plan_cfg.transparent_index
                                                    : 8'($urandom);
                    ctl_hit = plan_cfg.frame_flags[FLAG_CONTROL]
                            && cidx == plan_cfg.transparent_index;
                    // load any entry the pixel is about to read
                    if (ctl_hit && !plan_cfg.frame_flags[FLAG_TRANSP]) begin
                        if (!loaded[plan_cfg.background_index])
                            send(pal_item(plan_cfg.background_index));
                    end else if (!ctl_hit && !loaded[cidx]) begin
                        send(pal_item(cidx));
                    end
                    send(pix_item(cidx));
                end
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pixel_writes_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
